FILE: sv/swrr_pkg.sv
// Shared widths, codes and defaults for the smooth weighted round-robin picker.
package swrr_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam int CREDIT_W = 12;   // signed running credit
  localparam int TOTAL_W  = 12;   // sum of weights, at most 8 * 255
  localparam int DELTA_W  = 13;   // signed operand into the saturating adder
  localparam int CFG_W    = 64;

  typedef logic signed [CREDIT_W-1:0] credit_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;

  typedef enum logic [1:0] {
    KIND_PICK  = 2'd0,
    KIND_DEAD  = 2'd1,
    KIND_ALIVE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_WEIGHT_TABLE   = 2'd0,
    REG_DEFAULT_WEIGHT = 2'd1,
    REG_SLOTS_IN_USE   = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

endpackage

FILE: sv/swrr_sat_add.sv
// Saturating adder shared by the credit update and the winner's subtract.
module swrr_sat_add (
  input  swrr_pkg::credit_t a,
  input  swrr_pkg::delta_t  b,
  output swrr_pkg::credit_t y
);

  localparam int SUM_W = swrr_pkg::DELTA_W + 1;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] max_v;
  logic signed [SUM_W-1:0] min_v;

  assign max_v = SUM_W'((1 << (swrr_pkg::CREDIT_W - 1)) - 1);
  assign min_v = -SUM_W'(1 << (swrr_pkg::CREDIT_W - 1));
  assign sum   = SUM_W'(a) + SUM_W'(b);

  always_comb begin
    priority if (sum > max_v) begin
      y = max_v[swrr_pkg::CREDIT_W-1:0];
    end else if (sum < min_v) begin
      y = min_v[swrr_pkg::CREDIT_W-1:0];
    end else begin
      y = sum[swrr_pkg::CREDIT_W-1:0];
    end
  end

endmodule

FILE: sv/smooth_weighted_round_robin.sv
// Smooth weighted round-robin picker: busy is high while a pick runs through its scan
// (one slot per cycle through a single saturating adder) and then charges the
// winner, and found/chosen appear with done for one cycle right after busy falls;
// the receiver cannot stall, so done must be sampled then. Mark items (dead/alive)
// are taken without raising busy and give no done. cfg_ready is low
// while a pick runs; any write to a listed register clears all credits at once.
module smooth_weighted_round_robin #(
  parameter int SLOTS       = swrr_pkg::SLOTS_DEF,
  parameter int WEIGHT_BITS = swrr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               kind,
  input  logic [2:0]               slot,
  output logic                     done,
  output logic                     found,
  output logic [2:0]               chosen,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [swrr_pkg::CFG_W-1:0] cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_SUB  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [swrr_pkg::CFG_W-1:0] weight_table;
  logic [7:0]                 dflt_weight;
  logic [3:0]                 slots_in_use;
  logic [SLOTS-1:0]           alive_mask;

  swrr_pkg::credit_t credit [SLOTS];

  logic [IDX_W-1:0]            idx;
  logic [swrr_pkg::TOTAL_W-1:0] total;
  logic                        best_found;
  logic [IDX_W-1:0]            best_idx;
  swrr_pkg::credit_t           best_val;

  logic                   accept;
  logic                   cfg_write;
  logic                   cfg_hit;
  logic [IDX_W-1:0]       rd_addr;
  swrr_pkg::credit_t      cur;
  logic [7:0]             wbyte;
  logic [WEIGHT_BITS-1:0] w;
  logic                   take_part;
  swrr_pkg::delta_t       delta;
  swrr_pkg::credit_t      upd;
  logic                   last;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_write && (cfg_index != swrr_pkg::REG_UNUSED);
  assign last      = (idx == IDX_W'(SLOTS - 1));

  // single credit read port: scan slot, or the winner in the charge cycle
  assign rd_addr = (state == ST_SUB) ? best_idx : idx;
  assign cur     = credit[rd_addr];

  assign wbyte = weight_table[idx*8 +: 8];

  always_comb begin
    w = wbyte[WEIGHT_BITS-1:0];
    if (w == '0) begin
      w = dflt_weight[WEIGHT_BITS-1:0];
    end
    if (w == '0) begin
      w = WEIGHT_BITS'(1);
    end
  end

  assign take_part = (4'(idx) < slots_in_use) && alive_mask[idx];

  assign delta = (state == ST_SUB) ? -$signed({1'b0, total})
                                   : $signed(swrr_pkg::DELTA_W'(w));

  swrr_sat_add u_alu (
    .a (cur),
    .b (delta),
    .y (upd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind == swrr_pkg::KIND_PICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      weight_table   <= '0;
      dflt_weight    <= 8'd1;
      slots_in_use   <= 4'd8;
      alive_mask     <= '1;
      idx            <= '0;
      total          <= '0;
      best_found     <= 1'b0;
      best_idx       <= '0;
      best_val       <= '0;
      done           <= 1'b0;
      found          <= 1'b0;
      chosen         <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        credit[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= 1'b0;

      if (cfg_write) begin
        unique case (cfg_index)
          swrr_pkg::REG_WEIGHT_TABLE:   weight_table   <= cfg_data;
          swrr_pkg::REG_DEFAULT_WEIGHT: dflt_weight    <= cfg_data[7:0];
          swrr_pkg::REG_SLOTS_IN_USE:   slots_in_use   <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        for (int i = 0; i < SLOTS; i++) begin
          credit[i] <= '0;
        end
      end

      if (accept) begin
        if (kind == swrr_pkg::KIND_DEAD && int'(slot) < SLOTS) begin
          alive_mask[slot[IDX_W-1:0]] <= 1'b0;
        end
        if (kind == swrr_pkg::KIND_ALIVE && int'(slot) < SLOTS) begin
          alive_mask[slot[IDX_W-1:0]] <= 1'b1;
        end
        idx        <= '0;
        total      <= '0;
        best_found <= 1'b0;
        best_idx   <= '0;
        best_val   <= '0;
      end

      if (state == ST_SCAN) begin
        if (take_part) begin
          credit[idx] <= upd;
          total       <= total + swrr_pkg::TOTAL_W'(w);
          if (!best_found || upd > best_val) begin
            best_found <= 1'b1;
            best_idx   <= idx;
            best_val   <= upd;
          end
        end
        if (!last) begin
          idx <= idx + IDX_W'(1);
        end
      end

      if (state == ST_SUB) begin
        if (best_found) begin
          credit[best_idx] <= upd;
        end
        done   <= 1'b1;
        found  <= best_found;
        chosen <= best_found ? 3'(best_idx) : 3'd0;
      end
    end
  end

  a_done_after_charge: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SUB))
    else $error("done without a charge cycle");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> chosen == 3'd0)
    else $error("chosen not zero when nothing found");

  a_found_in_use: assert property (@(posedge clk) disable iff (rst)
    done && found |-> 4'(chosen) < slots_in_use)
    else $error("chosen slot not in use");

  a_winner_has_total: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUB && best_found |-> total != '0)
    else $error("winner with empty total");

endmodule
